// ----- design/scancode_to_ascii_decoder_core_assert.svh -----
// assertion macros shared by the scan code decoder modules
`ifndef SCANCODE_TO_ASCII_DECODER_CORE_ASSERT_SVH
`define SCANCODE_TO_ASCII_DECODER_CORE_ASSERT_SVH

// checked outside reset
`define SCD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked during reset too
`define SCD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/scd_pkg.sv -----
// types, codes and the us key table of the scan code decoder
package scd_pkg;

  localparam logic [7:0] CODE_EXT     = 8'hE0;
  localparam logic [7:0] CODE_LSHIFT  = 8'h2A;
  localparam logic [7:0] CODE_RSHIFT  = 8'h36;
  localparam logic [7:0] CODE_CTRL    = 8'h1D;
  localparam logic [7:0] CODE_ALT     = 8'h38;
  localparam logic [7:0] CODE_CAPS    = 8'h3A;
  localparam logic [7:0] KEY_COUNT    = 8'd58;
  localparam logic [6:0] CHAR_LOW_A   = 7'h61;
  localparam logic [6:0] CHAR_LOW_Z   = 7'h7A;

  typedef struct packed {
    logic [6:0] normal;
    logic [6:0] shifted;
    logic [6:0] ctl;
  } key_entry_t;

  typedef struct packed {
    logic shift_held;
    logic ctrl_held;
    logic alt_held;
    logic caps_on;
    logic extended_pending;
  } flags_t;

  typedef struct packed {
    logic       hit;
    logic [6:0] ch;
  } dec_res_t;

  function automatic key_entry_t key_lookup(input logic [5:0] idx);
    key_entry_t e;
    unique case (idx)
      6'd1:  e = '{7'h1B, 7'h1B, 7'h1B};
      6'd2:  e = '{7'h31, 7'h21, 7'h00};
      6'd3:  e = '{7'h32, 7'h40, 7'h00};
      6'd4:  e = '{7'h33, 7'h23, 7'h00};
      6'd5:  e = '{7'h34, 7'h24, 7'h00};
      6'd6:  e = '{7'h35, 7'h25, 7'h00};
      6'd7:  e = '{7'h36, 7'h5E, 7'h1E};
      6'd8:  e = '{7'h37, 7'h26, 7'h00};
      6'd9:  e = '{7'h38, 7'h2A, 7'h00};
      6'd10: e = '{7'h39, 7'h28, 7'h00};
      6'd11: e = '{7'h30, 7'h29, 7'h00};
      6'd12: e = '{7'h2D, 7'h5F, 7'h1F};
      6'd13: e = '{7'h3D, 7'h2B, 7'h00};
      6'd14: e = '{7'h08, 7'h08, 7'h7F};
      6'd15: e = '{7'h09, 7'h09, 7'h09};
      6'd16: e = '{7'h71, 7'h51, 7'h11};
      6'd17: e = '{7'h77, 7'h57, 7'h17};
      6'd18: e = '{7'h65, 7'h45, 7'h05};
      6'd19: e = '{7'h72, 7'h52, 7'h12};
      6'd20: e = '{7'h74, 7'h54, 7'h14};
      6'd21: e = '{7'h79, 7'h59, 7'h19};
      6'd22: e = '{7'h75, 7'h55, 7'h15};
      6'd23: e = '{7'h69, 7'h49, 7'h09};
      6'd24: e = '{7'h6F, 7'h4F, 7'h0F};
      6'd25: e = '{7'h70, 7'h50, 7'h10};
      6'd26: e = '{7'h5B, 7'h7B, 7'h1B};
      6'd27: e = '{7'h5D, 7'h7D, 7'h1D};
      6'd28: e = '{7'h0A, 7'h0A, 7'h0A};
      6'd30: e = '{7'h61, 7'h41, 7'h01};
      6'd31: e = '{7'h73, 7'h53, 7'h13};
      6'd32: e = '{7'h64, 7'h44, 7'h04};
      6'd33: e = '{7'h66, 7'h46, 7'h06};
      6'd34: e = '{7'h67, 7'h47, 7'h07};
      6'd35: e = '{7'h68, 7'h48, 7'h08};
      6'd36: e = '{7'h6A, 7'h4A, 7'h0A};
      6'd37: e = '{7'h6B, 7'h4B, 7'h0B};
      6'd38: e = '{7'h6C, 7'h4C, 7'h0C};
      6'd39: e = '{7'h3B, 7'h3A, 7'h00};
      6'd40: e = '{7'h27, 7'h22, 7'h00};
      6'd41: e = '{7'h60, 7'h7E, 7'h00};
      6'd43: e = '{7'h5C, 7'h7C, 7'h1C};
      6'd44: e = '{7'h7A, 7'h5A, 7'h1A};
      6'd45: e = '{7'h78, 7'h58, 7'h18};
      6'd46: e = '{7'h63, 7'h43, 7'h03};
      6'd47: e = '{7'h76, 7'h56, 7'h16};
      6'd48: e = '{7'h62, 7'h42, 7'h02};
      6'd49: e = '{7'h6E, 7'h4E, 7'h0E};
      6'd50: e = '{7'h6D, 7'h4D, 7'h0D};
      6'd51: e = '{7'h2C, 7'h3C, 7'h00};
      6'd52: e = '{7'h2E, 7'h3E, 7'h00};
      6'd53: e = '{7'h2F, 7'h3F, 7'h00};
      6'd57: e = '{7'h20, 7'h20, 7'h20};
      default: e = '{7'h00, 7'h00, 7'h00};
    endcase
    return e;
  endfunction

endpackage

// ----- design/scd_decode.sv -----
// modifier flag registers and per-code decode into a character
`include "scancode_to_ascii_decoder_core_assert.svh"

module scd_decode (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  logic [7:0]        code,
  output scd_pkg::dec_res_t res
);
  import scd_pkg::*;

  flags_t     flags_r;
  flags_t     flags_nxt;
  key_entry_t entry;
  logic       letter;
  logic [6:0] ch;
  logic [6:0] base;

  always_comb begin
    entry  = (code < KEY_COUNT) ? key_lookup(code[5:0]) : '0;
    letter = (entry.normal >= CHAR_LOW_A) && (entry.normal <= CHAR_LOW_Z);
    if (flags_r.ctrl_held && (entry.ctl != 7'd0)) begin
      ch = entry.ctl;
    end else if (flags_r.shift_held || (flags_r.caps_on && letter)) begin
      ch = entry.shifted;
    end else begin
      ch = entry.normal;
    end
  end

  always_comb begin
    flags_nxt = flags_r;
    res.hit   = 1'b0;
    res.ch    = ch;
    base      = code[6:0];
    priority if (code == CODE_EXT) begin
      flags_nxt.extended_pending = 1'b1;
    end else if (code[7]) begin
      if (base == CODE_LSHIFT[6:0] || base == CODE_RSHIFT[6:0]) begin
        flags_nxt.shift_held = 1'b0;
      end else if (base == CODE_CTRL[6:0]) begin
        flags_nxt.ctrl_held = 1'b0;
      end else if (base == CODE_ALT[6:0]) begin
        flags_nxt.alt_held = 1'b0;
      end
      flags_nxt.extended_pending = 1'b0;
    end else if (code == CODE_LSHIFT || code == CODE_RSHIFT) begin
      flags_nxt.shift_held       = 1'b1;
      flags_nxt.extended_pending = 1'b0;
    end else if (code == CODE_CTRL) begin
      flags_nxt.ctrl_held        = 1'b1;
      flags_nxt.extended_pending = 1'b0;
    end else if (code == CODE_ALT) begin
      flags_nxt.alt_held         = 1'b1;
      flags_nxt.extended_pending = 1'b0;
    end else if (code == CODE_CAPS) begin
      flags_nxt.caps_on          = ~flags_r.caps_on;
      flags_nxt.extended_pending = 1'b0;
    end else if (flags_r.extended_pending) begin
      flags_nxt.extended_pending = 1'b0;
    end else begin
      res.hit = (ch != 7'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
    end else if (fire) begin
      flags_r <= flags_nxt;
    end
  end

  `SCD_ASSERT(a_ext_sets, (fire && code == CODE_EXT) |=> flags_r.extended_pending, "prefix not held")
  `SCD_ASSERT(a_ext_drops, (fire && flags_r.extended_pending) |-> !res.hit, "extended key decoded")
  `SCD_ASSERT(a_idle_holds, !fire |=> $stable(flags_r), "flags moved without a beat")

endmodule

// ----- design/scd_out_reg.sv -----
// result register that parts the decode stage from the output channel
`include "scancode_to_ascii_decoder_core_assert.svh"

module scd_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  scd_pkg::dec_res_t res,
  input  logic              out_tready,
  output logic              out_tvalid,
  output logic [7:0]        out_tdata,
  output logic              free
);
  import scd_pkg::*;

  logic       valid_r;
  logic       valid_nxt;
  logic [6:0] ch_r;

  assign free       = !valid_r || out_tready;
  assign valid_nxt  = free ? (load && res.hit) : valid_r;
  assign out_tvalid = valid_r;
  assign out_tdata  = {1'b0, ch_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (free) begin
      ch_r <= res.ch;
    end
  end

  `SCD_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !valid_r, "result valid after reset")
  `SCD_ASSERT(a_nonzero, valid_r |-> (ch_r != 7'd0), "zero character shown")
  `SCD_ASSERT(a_load_shows, (free && load && res.hit) |=> valid_r, "decoded key lost")

endmodule

// ----- design/scancode_to_ascii_decoder_core.sv -----
// top level of the ps/2 set 1 scan code to ascii decoder
//
//  channel | dir | tdata fields (low bit up)       | beat when
//  in_     | in  | scan_code[7:0]                  | in_tvalid && in_tready
//  out_    | out | ascii_char[6:0], zero pad [7]   | out_tvalid && out_tready
//
// one beat per cycle sustained unless the output stalls; a character is registered before and after its lookup
// the path is input register, table lookup and flag update, result register
// reset clears flags and both valid bits; no clearing pass
// a stalled output holds the result and the input register, then in_tready drops
`include "scancode_to_ascii_decoder_core_assert.svh"

module scancode_to_ascii_decoder_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // scan_code[7:0]
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // ascii_char[6:0], zero [7]
);
  import scd_pkg::*;

  logic       in_valid_r;
  logic       in_valid_nxt;
  logic [7:0] in_code_r;
  logic       advance;
  logic       fire;
  dec_res_t   res;
  dec_res_t   res_gated;

  assign in_tready    = !in_valid_r || advance;
  assign fire         = in_valid_r && advance;
  assign in_valid_nxt = in_tready ? in_tvalid : in_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready) begin
      in_code_r <= in_tdata;
    end
  end

  scd_decode u_decode (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .code  (in_code_r),
    .res   (res)
  );

  always_comb begin
    res_gated     = res;
    res_gated.hit = res.hit && in_valid_r;
  end

  scd_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (fire),
    .res        (res_gated),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .free       (advance)
  );

  `SCD_ASSERT(a_stall_blocks, (in_valid_r && out_tvalid && !out_tready) |-> !in_tready, "beat taken while stalled")
  `SCD_ASSERT(a_empty_ready, !in_valid_r |-> in_tready, "empty stage not ready")
  `SCD_ASSERT(a_beat_held, (in_valid_r && !advance) |=> in_valid_r, "held scan byte dropped")

endmodule
